>>> rtl/core/rmsd_acc_pkg.sv
package rmsd_acc_pkg;

   // Default field and counter widths, and run queue depth
   localparam int DEF_COORD_BITS = 20;
   localparam int DEF_COUNT_BITS = 16;
   localparam int DEF_QUEUE_DEPTH = 2;

   // Running sum of squared differences, saturating
   localparam int SUM_BITS = 60;

   // Square root of the mean, and its clipped output form
   localparam int ROOT_BITS = SUM_BITS / 2;
   localparam int RMS_BITS = 21;
   localparam int RSP_DATA_BITS = ((RMS_BITS + 7) / 8) * 8;

   // Result status codes
   localparam int STATUS_BITS = 2;
   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

>>> rtl/core/rmsd_acc_front.sv
module rmsd_acc_front
   import rmsd_acc_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   localparam int REQ_BITS = ((6 * COORD_BITS + 7) / 8) * 8,
   localparam int QCW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cmp_x, cmp_y, cmp_z, ref_x, ref_y, ref_z from the lowest bit up
   input  logic [REQ_BITS-1:0]   req_tdata,
   input  logic                  req_tlast,
   input  logic [QCW-1:0]        q_count,
   output logic                  push,
   output logic [SUM_BITS-1:0]   push_sum,
   output logic [COUNT_BITS-1:0] push_count,
   output logic                  push_ovf
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int SQ_BITS = 2 * DIFF_BITS;
   localparam int SUM_W1 = SUM_BITS + 1;

   logic                  accept;
   logic [DIFF_BITS-1:0]  cmp_ext [3];
   logic [DIFF_BITS-1:0]  refc_ext [3];
   logic [DIFF_BITS-1:0]  diff [3];
   logic [DIFF_BITS-1:0]  mag [3];
   logic [SQ_BITS-1:0]    sq_in [3];
   logic [SQ_BITS-1:0]    sq_ff [3];
   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic [SUM_W1-1:0]     pair_add;
   logic [SUM_W1-1:0]     sum_total;
   logic [SUM_BITS-1:0]   sum_next;
   logic [COUNT_BITS-1:0] count_next;
   logic                  ovf_next;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [SUM_BITS-1:0]   sum_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  ovf_ff;
   logic                  ovf_in;

   // Hold off while a last beat in flight could find the queue full
   assign req_tready = (QCW'(q_count) + QCW'(s1_valid_ff & s1_last_ff)) < QCW'(QUEUE_DEPTH);
   assign accept = req_tvalid & req_tready;

   // Stage one: absolute differences, squared
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cmp_ext[i] = {req_tdata[i*COORD_BITS + COORD_BITS - 1],
                       req_tdata[i*COORD_BITS +: COORD_BITS]};
         refc_ext[i] = {req_tdata[(i+3)*COORD_BITS + COORD_BITS - 1],
                        req_tdata[(i+3)*COORD_BITS +: COORD_BITS]};
         diff[i] = cmp_ext[i] - refc_ext[i];
         mag[i] = diff[i][DIFF_BITS-1] ? (~diff[i] + DIFF_BITS'(1)) : diff[i];
         sq_in[i] = SQ_BITS'(mag[i]) * SQ_BITS'(mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= req_tlast;
         sq_ff <= sq_in;
      end
   end

   // Stage two: saturating accumulate and count
   always_comb begin
      pair_add = SUM_W1'(sq_ff[0]) + SUM_W1'(sq_ff[1]) + SUM_W1'(sq_ff[2]);
      sum_total = SUM_W1'(sum_ff) + pair_add;
      sum_next = sum_total[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_total[SUM_BITS-1:0];
      count_next = (&count_ff) ? count_ff : count_ff + COUNT_BITS'(1);
      ovf_next = ovf_ff | (&count_ff);

      sum_in = sum_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            sum_in = '0;
            count_in = '0;
            ovf_in = 1'b0;
         end else begin
            sum_in = sum_next;
            count_in = count_next;
            ovf_in = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
   end

   // Close the run into the queue on the last beat
   assign push = s1_valid_ff & s1_last_ff;
   assign push_sum = sum_next;
   assign push_count = count_next;
   assign push_ovf = ovf_next;

endmodule

>>> rtl/core/rmsd_acc_queue.sv
module rmsd_acc_queue
   import rmsd_acc_pkg::*;
#(
   parameter int WIDTH = SUM_BITS + DEF_COUNT_BITS + 1,
   parameter int DEPTH = DEF_QUEUE_DEPTH,
   localparam int QCW = $clog2(DEPTH + 1),
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             not_empty,
   output logic [QCW-1:0]   count
);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [QCW-1:0]      count_ff;

   function automatic logic [PTR_BITS-1:0] ptr_advance(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] nxt;
      nxt = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
      return nxt;
   endfunction

   // Store on push
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_advance(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_advance(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCW'(1);
         end
      end
   end

   assign rd_data = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count = count_ff;

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QCW'(DEPTH)))
      else $error("queue written while full");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");
`endif

endmodule

>>> rtl/core/rmsd_acc_back.sv
module rmsd_acc_back
   import rmsd_acc_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   output logic                     pop,
   input  logic [SUM_BITS-1:0]      q_sum,
   input  logic [COUNT_BITS-1:0]    q_count,
   input  logic                     q_ovf,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rms_deviation, zero fill from the lowest bit up
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0]   rsp_tuser
);

   localparam int STEP_BITS = $clog2(SUM_BITS);
   localparam int REM_BITS = ROOT_BITS + 2;
   localparam int TRIAL_BITS = REM_BITS + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]             state_ff;
   logic [1:0]             state_in;
   logic [STEP_BITS-1:0]   step_ff;
   logic [STEP_BITS-1:0]   step_in;
   logic [SUM_BITS-1:0]    work_ff;
   logic [SUM_BITS-1:0]    work_in;
   logic [REM_BITS-1:0]    rem_ff;
   logic [REM_BITS-1:0]    rem_in;
   logic [ROOT_BITS-1:0]   root_ff;
   logic [ROOT_BITS-1:0]   root_in;
   logic [COUNT_BITS-1:0]  div_ff;
   logic [COUNT_BITS-1:0]  div_in;
   logic                   ovf_ff;
   logic                   ovf_in;
   logic                   empty_ff;
   logic                   empty_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RMS_BITS-1:0]    rsp_rms_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic                   rsp_load;
   logic [COUNT_BITS:0]    div_trial;
   logic [COUNT_BITS:0]    div_diff;
   logic                   div_ge;
   logic [TRIAL_BITS-1:0]  sq_part;
   logic [TRIAL_BITS-1:0]  sq_trial;
   logic [TRIAL_BITS-1:0]  sq_diff;
   logic                   sq_ge;
   logic [RMS_BITS-1:0]    rms_clip;
   logic [STATUS_BITS-1:0] status_code;

   // One quotient bit per step of the restoring divider
   assign div_trial = {rem_ff[COUNT_BITS-1:0], work_ff[SUM_BITS-1]};
   assign div_diff = div_trial - {1'b0, div_ff};
   assign div_ge = (div_trial >= {1'b0, div_ff});

   // One root bit per step of the digit-by-digit square root
   assign sq_part = {rem_ff, work_ff[SUM_BITS-1 -: 2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_diff = sq_part - sq_trial;
   assign sq_ge = (sq_part >= sq_trial);

   // Clip the root and pick the status
   assign rms_clip = (|root_ff[ROOT_BITS-1:RMS_BITS]) ? {RMS_BITS{1'b1}}
                                                      : root_ff[RMS_BITS-1:0];
   assign status_code = empty_ff ? STATUS_EMPTY : (ovf_ff ? STATUS_OVERFLOW : STATUS_OK);

   assign pop = (state_ff == ST_IDLE) && q_valid;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      work_in = work_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      div_in = div_ff;
      ovf_in = ovf_ff;
      empty_in = empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               work_in = q_sum;
               div_in = q_count;
               ovf_in = q_ovf;
               empty_in = (q_count == '0);
               rem_in = '0;
               root_in = '0;
               step_in = '0;
               state_in = (q_count == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            work_in = {work_ff[SUM_BITS-2:0], div_ge};
            rem_in = REM_BITS'(div_ge ? div_diff[COUNT_BITS-1:0]
                                      : div_trial[COUNT_BITS-1:0]);
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               rem_in = '0;
               step_in = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            work_in = {work_ff[SUM_BITS-3:0], 2'b00};
            rem_in = sq_ge ? sq_diff[REM_BITS-1:0] : sq_part[REM_BITS-1:0];
            root_in = {root_ff[ROOT_BITS-2:0], sq_ge};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(ROOT_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      div_ff <= div_in;
      ovf_ff <= ovf_in;
      empty_ff <= empty_in;
   end

   // Output register: hold until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_rms_ff <= empty_ff ? '0 : rms_clip;
         rsp_status_ff <= status_code;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DATA_BITS'(rsp_rms_ff);
   assign rsp_tuser = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_div_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < STEP_BITS'(SUM_BITS)))
      else $error("divider step out of range");

   a_empty_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_EMPTY)) |-> (rsp_rms_ff == '0))
      else $error("empty run with nonzero deviation");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the done state");
`endif

endmodule

>>> rtl/core/rmsd_accumulator_core.sv
// RMS deviation accumulator. Each req beat is one matched atom pair
// (compared and reference x, y, z, signed with 8 fractional bits); the front
// end takes one pair every cycle, squares the three differences and adds them
// into a saturating 60-bit sum while counting pairs (the count saturates and
// flags overflow). When the beat with tlast high reaches the accumulate stage,
// the closed run is pushed into a small queue and the accumulator starts afresh
// on the next cycle. The back end pops one run at a time, divides sum by count
// with a bit-serial restoring divider and takes the integer square root one
// bit a cycle; it pops the next run only once the result has gone into the
// output register. Pairs keep flowing at full rate unless the queue,
// counting a run that is closing in the accumulate stage, already holds
// QUEUE_DEPTH runs waiting for the back end, in which case req_tready drops.
// rsp_tuser carries the status: ok, empty run, or pair count overflow.
module rmsd_accumulator_core
   import rmsd_acc_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   localparam int REQ_BITS = ((6 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // cmp_x, cmp_y, cmp_z, ref_x, ref_y, ref_z, zero fill from the lowest bit up
   input  logic [REQ_BITS-1:0]      req_tdata,
   // last_pair
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rms_deviation, zero fill from the lowest bit up
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0]   rsp_tuser
);

   localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_BITS = SUM_BITS + COUNT_BITS + 1;

   logic                  push;
   logic [SUM_BITS-1:0]   push_sum;
   logic [COUNT_BITS-1:0] push_count;
   logic                  push_ovf;
   logic                  pop;
   logic [ENTRY_BITS-1:0] q_rd_data;
   logic                  q_valid;
   logic [QCW-1:0]        q_count;

   rmsd_acc_front #(
      .COORD_BITS  (COORD_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_count    (q_count),
      .push       (push),
      .push_sum   (push_sum),
      .push_count (push_count),
      .push_ovf   (push_ovf)
   );

   rmsd_acc_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_data   ({push_ovf, push_count, push_sum}),
      .pop       (pop),
      .rd_data   (q_rd_data),
      .not_empty (q_valid),
      .count     (q_count)
   );

   rmsd_acc_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .pop        (pop),
      .q_sum      (q_rd_data[SUM_BITS-1:0]),
      .q_count    (q_rd_data[SUM_BITS +: COUNT_BITS]),
      .q_ovf      (q_rd_data[ENTRY_BITS-1]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> verif/rmsd_accumulator_core_test.sv
module rmsd_accumulator_core_test;
   import rmsd_acc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W = DEF_COORD_BITS;
   localparam int COUNT_W = DEF_COUNT_BITS;
   localparam int REQ_W = ((6 * COORD_W + 7) / 8) * 8;

   localparam bit [63:0] SUM_CEIL = (64'd1 << SUM_BITS) - 64'd1;
   localparam bit [63:0] PAIRS_CEIL = (64'd1 << COUNT_W) - 64'd1;
   localparam bit [63:0] RMS_CEIL = (64'd1 << RMS_BITS) - 64'd1;

   typedef bit signed [COORD_W-1:0] coord_type;

   localparam coord_type C_MAX = coord_type'((64'd1 << (COORD_W - 1)) - 64'd1);
   localparam coord_type C_MIN = coord_type'(64'd1 << (COORD_W - 1));
   localparam coord_type C_ZERO = coord_type'(0);

   typedef struct {
      bit [RMS_BITS-1:0]    rms;
      bit [STATUS_BITS-1:0] status;
   } rmsd_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // cmp_x, cmp_y, cmp_z, ref_x, ref_y, ref_z, zero fill from the lowest bit up
   logic [REQ_W-1:0]         req_tdata = '0;
   // last_pair
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // rms_deviation, zero fill from the lowest bit up
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // status
   logic [STATUS_BITS-1:0]   rsp_tuser;

   // Running state of the deviation predictor
   bit [63:0]       sq_sum;
   bit [63:0]       pairs_seen;
   bit              pairs_full;
   rmsd_result_type rmsd_expect_q[$];
   rmsd_result_type rmsd_head;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;

   rmsd_accumulator_core #(
      .COORD_BITS(COORD_W),
      .COUNT_BITS(COUNT_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare each result beat with the oldest expected deviation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rmsd_expect_q.size() == 0) begin
            $display("%0t: result beat with nothing expected: rms %0d status %0d",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            rmsd_head = rmsd_expect_q.pop_front();
            if (rsp_tdata !== RSP_DATA_BITS'(rmsd_head.rms)) begin
               $display("%0t: rms_deviation expected %0d actual %0d",
                        $time, rmsd_head.rms, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== rmsd_head.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, rmsd_head.status, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // Floor of the square root, one result bit at a time from the top
   function automatic bit [31:0] floor_root(input bit [63:0] v);
      bit [31:0] root;
      bit [31:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= v) root = trial;
      end
      return root;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(7))
         0: return C_MIN;
         1: return C_MAX;
         2: return C_ZERO;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Offer one atom pair, wait for its beat, then fold it into the prediction
   task automatic send_pair(input coord_type cx, input coord_type cy, input coord_type cz,
                            input coord_type rx, input coord_type ry, input coord_type rz,
                            input bit last);
      longint signed   dx;
      longint signed   dy;
      longint signed   dz;
      bit [63:0]       add;
      bit [63:0]       mean;
      bit [63:0]       root;
      rmsd_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= REQ_W'({rz, ry, rx, cz, cy, cx});
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);

      dx = longint'(cx) - longint'(rx);
      dy = longint'(cy) - longint'(ry);
      dz = longint'(cz) - longint'(rz);
      add = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
      // Saturate the sum rather than wrap
      if (add > SUM_CEIL - sq_sum) sq_sum = SUM_CEIL;
      else sq_sum += add;
      // Hold the count at its ceiling and flag the extra pairs
      if (pairs_seen >= PAIRS_CEIL) pairs_full = 1'b1;
      else pairs_seen++;

      if (last) begin
         if (pairs_seen == 0) begin
            res.rms = '0;
            res.status = STATUS_EMPTY;
         end else begin
            mean = sq_sum / pairs_seen;
            root = 64'(floor_root(mean));
            if (root > RMS_CEIL) root = RMS_CEIL;
            res.rms = root[RMS_BITS-1:0];
            res.status = pairs_full ? STATUS_OVERFLOW : STATUS_OK;
         end
         rmsd_expect_q.insert(rmsd_expect_q.size(), res);
         sq_sum = '0;
         pairs_seen = '0;
         pairs_full = 1'b0;
      end
      @(negedge clock);
   endtask

   // Single-pair runs at the coordinate extremes and around zero
   task automatic test_directed_extremes();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_pair(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1'b1);
      send_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1);
      send_pair(C_MAX, C_ZERO, C_MIN, C_MIN, C_ZERO, C_MAX, 1'b1);
      send_pair(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b1);
      send_pair(C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, 1'b1);
      send_pair(coord_type'(-1), C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b1);
      send_pair(coord_type'(1), coord_type'(1), coord_type'(1),
                C_ZERO, C_ZERO, C_ZERO, 1'b1);
      send_pair(C_MAX, C_MAX, C_MAX, C_MAX - coord_type'(1), C_MAX - coord_type'(1),
                C_MAX - coord_type'(1), 1'b1);
   endtask

   // Truncation of both the division and the root over two short runs
   task automatic test_truncating_run();
      send_pair(coord_type'(3), C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0);
      send_pair(C_ZERO, coord_type'(5), C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b0);
      send_pair(C_ZERO, C_ZERO, coord_type'(-7), C_ZERO, C_ZERO, C_ZERO, 1'b1);
      send_pair(coord_type'(256), coord_type'(-256), coord_type'(2),
                C_ZERO, C_ZERO, C_ZERO, 1'b0);
      send_pair(C_ZERO, C_ZERO, C_ZERO, coord_type'(1), coord_type'(1), C_ZERO, 1'b1);
   endtask

   // Close runs on every beat at full rate so the run queue fills up
   task automatic test_back_to_back_runs();
      for (int i = 0; i < 10; i++) begin
         send_pair(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), 1'b1);
      end
   endtask

   // Random runs, mostly short, with mostly small deviations around a random base
   task automatic test_random_runs(input int idle_pct, input int stall_pct,
                                   input int n_items);
      int        done;
      int        run_len;
      coord_type bx;
      coord_type by;
      coord_type bz;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      done = 0;
      while (done < n_items) begin
         run_len = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
         for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(9) < 6) begin
               bx = rand_coord();
               by = rand_coord();
               bz = rand_coord();
               send_pair(bx + coord_type'($urandom_range(1023)) - coord_type'(512),
                         by + coord_type'($urandom_range(1023)) - coord_type'(512),
                         bz + coord_type'($urandom_range(1023)) - coord_type'(512),
                         bx, by, bz, k == run_len - 1);
            end else begin
               send_pair(rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), k == run_len - 1);
            end
         end
         done += run_len;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_truncating_run();
      test_back_to_back_runs();
      test_random_runs(0, 0, 100);
      test_random_runs(67, 0, 100);
      test_random_runs(0, 67, 100);
      test_random_runs(24, 24, 100);

      // Drain: wait for every expected result, then allow the back end to settle
      req_tvalid <= 1'b0;
      while (rmsd_expect_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/rmsd_acc_pkg.sv
rtl/core/rmsd_acc_front.sv
rtl/core/rmsd_acc_queue.sv
rtl/core/rmsd_acc_back.sv
rtl/core/rmsd_accumulator_core.sv
verif/rmsd_accumulator_core_test.sv
